// ----- hw/rtl/iol_pkg.sv -----
package iol_pkg;

   localparam int DATA_W           = 32;
   localparam int ACT_W            = 3;
   localparam int POS_W            = 11;
   localparam int CNT_OUT_W        = 11;
   localparam int DEFAULT_CAPACITY = 1024;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type FAIL_VALUE = data_type'(-1);

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND    = 3'd0,
      ACT_PREPEND   = 3'd1,
      ACT_INSERT    = 3'd2,
      ACT_POP_LAST  = 3'd3,
      ACT_POP_FIRST = 3'd4,
      ACT_POP_AT    = 3'd5,
      ACT_READ_AT   = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_LOAD,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      data_type    value;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ----- hw/rtl/iol_req_if.sv -----
interface iol_req_if
   import iol_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [ACT_W-1:0]       action;
   logic signed [DATA_W-1:0] item_value;
   logic [POS_W-1:0]       position;

   modport source (output valid, action, item_value, position, input ready);
   modport sink   (input valid, action, item_value, position, output ready);
endinterface

// ----- hw/rtl/iol_rsp_if.sv -----
interface iol_rsp_if
   import iol_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] read_value;
   logic [CNT_OUT_W-1:0]     count;

   modport source (output valid, ok, read_value, count, input ready);
   modport sink   (input valid, ok, read_value, count, output ready);
endinterface

// ----- hw/rtl/indexed_ordered_list.sv -----
// Bounded ordered list of CAPACITY signed 32-bit entries held in a row of
// shifting cells. Append, prepend and insert at a position shift the later
// cells up by one and, like any request that fails, are answered from the
// response register; the next beat is taken in the following cycle once
// that register is free. Read at, remove at, remove first and remove last
// at position k copy all cells into a tap chain that moves one cell toward
// the head per cycle, then take k shifts and a result step that waits for
// a free response register; remove last has k = count - 1. Removal shifts
// the later cells down in the result cycle. A failed request leaves the
// list as it was and returns -1. Entries need no clearing after reset.
module indexed_ordered_list
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   iol_req_if.sink   req_if,
   iol_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctrl_type    cell_ctrl;
   logic [IDX_W-1:0] cell_pos;
   data_type         cell_value [CAPACITY];
   data_type         cell_tap   [CAPACITY];

   iol_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .head_tap  (cell_tap[0]),
      .cell_ctrl (cell_ctrl),
      .cell_pos  (cell_pos)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_value, right_value, right_tap;

      if (i == 0) begin : g_head
         assign left_value = cell_value[0];
      end else begin : g_body
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
         assign right_tap   = cell_tap[i];
      end else begin : g_next
         assign right_value = cell_value[i+1];
         assign right_tap   = cell_tap[i+1];
      end

      iol_cell #(
         .IDX   (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .pos         (cell_pos),
         .left_value  (left_value),
         .right_value (right_value),
         .right_tap   (right_tap),
         .value       (cell_value[i]),
         .tap         (cell_tap[i])
      );
   end

`ifndef SYNTH
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ok |-> rsp_if.read_value == FAIL_VALUE)
      else $error("failed response without fail value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> 32'(rsp_if.count) <= CAPACITY)
      else $error("count beyond capacity");

   a_load_on_beat: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.op == CELL_LOAD |-> req_if.valid && req_if.ready)
      else $error("tap load without request beat");

   a_remove_result: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.op == CELL_REMOVE |=> rsp_if.valid && rsp_if.ok)
      else $error("removal without successful response");
`endif

endmodule

// ----- hw/rtl/iol_cell.sv -----
module iol_cell
   import iol_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int IDX_W = 10
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [IDX_W-1:0] pos,
   input  data_type         left_value,
   input  data_type         right_value,
   input  data_type         right_tap,
   output data_type         value,
   output data_type         tap
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   data_type value_ff, value_in;
   data_type tap_ff, tap_in;

   always_comb begin
      value_in = value_ff;
      tap_in   = tap_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_IDX > pos) begin
               value_in = left_value;
            end else if (MY_IDX == pos) begin
               value_in = ctrl.value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= pos) begin
               value_in = right_value;
            end
         end
         CELL_LOAD:  tap_in = value_ff;
         CELL_SHIFT: tap_in = right_tap;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
   end

   assign value = value_ff;
   assign tap   = tap_ff;

endmodule

// ----- hw/rtl/iol_ctrl.sv -----
module iol_ctrl
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int IDX_W    = 10,
   parameter int CNT_W    = 11
) (
   input  logic             clock,
   input  logic             reset,
   iol_req_if.sink          req,
   iol_rsp_if.source        rsp,
   input  data_type         head_tap,
   output cell_ctrl_type    cell_ctrl,
   output logic [IDX_W-1:0] cell_pos
);

   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     sel_ff, sel_in;
   logic [IDX_W-1:0]     remain_ff, remain_in;
   logic                 is_remove_ff, is_remove_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_ok_ff, out_ok_in;
   data_type             out_value_ff, out_value_in;
   logic [CNT_OUT_W-1:0] out_count_ff, out_count_in;

   logic [CMP_W-1:0] pos_ext, cnt_ext;
   logic             full, empty, fire, out_free;
   logic             dec_put, dec_take, dec_remove;
   logic [IDX_W-1:0] dec_at;

   assign pos_ext  = CMP_W'(req.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign out_free = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign fire     = req.valid && req.ready;

   always_comb begin
      dec_put    = 1'b0;
      dec_take   = 1'b0;
      dec_remove = 1'b0;
      dec_at     = '0;
      case (action_type'(req.action))
         ACT_APPEND: begin
            dec_put = !full;
            dec_at  = IDX_W'(count_ff);
         end
         ACT_PREPEND: begin
            dec_put = !full;
         end
         ACT_INSERT: begin
            dec_put = !full && (pos_ext <= cnt_ext);
            dec_at  = IDX_W'(pos_ext);
         end
         ACT_POP_LAST: begin
            dec_take   = !empty;
            dec_remove = 1'b1;
            dec_at     = IDX_W'(count_ff - CNT_W'(1));
         end
         ACT_POP_FIRST: begin
            dec_take   = !empty;
            dec_remove = 1'b1;
         end
         ACT_POP_AT: begin
            dec_take   = pos_ext < cnt_ext;
            dec_remove = 1'b1;
            dec_at     = IDX_W'(pos_ext);
         end
         ACT_READ_AT: begin
            dec_take = pos_ext < cnt_ext;
            dec_at   = IDX_W'(pos_ext);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire && dec_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (remain_ff == '0 && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.value = req.item_value;
      cell_pos        = sel_ff;
      count_in        = count_ff;
      sel_in          = sel_ff;
      remain_in       = remain_ff;
      is_remove_in    = is_remove_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_ok_in       = out_ok_ff;
      out_value_in    = out_value_ff;
      out_count_in    = out_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               if (dec_put) begin
                  cell_ctrl.op = CELL_INSERT;
                  cell_pos     = dec_at;
                  count_in     = count_ff + CNT_W'(1);
                  out_valid_in = 1'b1;
                  out_ok_in    = 1'b1;
                  out_value_in = FAIL_VALUE;
                  out_count_in = CNT_OUT_W'(count_ff + CNT_W'(1));
               end else if (dec_take) begin
                  cell_ctrl.op = CELL_LOAD;
                  sel_in       = dec_at;
                  remain_in    = dec_at;
                  is_remove_in = dec_remove;
               end else begin
                  out_valid_in = 1'b1;
                  out_ok_in    = 1'b0;
                  out_value_in = FAIL_VALUE;
                  out_count_in = CNT_OUT_W'(count_ff);
               end
            end
         end
         ST_SCAN: begin
            if (remain_ff != '0) begin
               cell_ctrl.op = CELL_SHIFT;
               remain_in    = remain_ff - IDX_W'(1);
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_ok_in    = 1'b1;
               out_value_in = head_tap;
               if (is_remove_ff) begin
                  cell_ctrl.op = CELL_REMOVE;
                  count_in     = count_ff - CNT_W'(1);
                  out_count_in = CNT_OUT_W'(count_ff - CNT_W'(1));
               end else begin
                  out_count_in = CNT_OUT_W'(count_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff       <= sel_in;
      remain_ff    <= remain_in;
      is_remove_ff <= is_remove_in;
      out_ok_ff    <= out_ok_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.ok         = out_ok_ff;
   assign rsp.read_value = out_value_ff;
   assign rsp.count      = out_count_ff;

endmodule

// ----- tb/sv/list_reply_checker.sv -----
`timescale 1ns / 1ps

module list_reply_checker
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   iol_req_if   req_mon,
   iol_rsp_if   rsp_mon,
   output int   fail_count,
   output int   list_len,
   output int   pending
);

   localparam int SHOWN_FAULTS = 10;

   typedef struct {
      logic                 ok;
      data_type             value;
      logic [CNT_OUT_W-1:0] count;
   } list_reply_type;

   data_type       list_shadow[$];
   list_reply_type reply_queue[$];

   function automatic list_reply_type apply_request(logic [ACT_W-1:0] act, data_type value,
                                                    logic [POS_W-1:0] pos);
      list_reply_type rep;
      int             len;
      int             at;
      len       = list_shadow.size();
      at        = int'(pos);
      rep.ok    = 1'b0;
      rep.value = FAIL_VALUE;
      case (act)
         ACT_APPEND: begin
            if (len < CAPACITY) begin
               list_shadow.push_back(value);
               rep.ok = 1'b1;
            end
         end
         ACT_PREPEND: begin
            if (len < CAPACITY) begin
               list_shadow.push_front(value);
               rep.ok = 1'b1;
            end
         end
         ACT_INSERT: begin
            if (len < CAPACITY && at <= len) begin
               list_shadow.insert(at, value);
               rep.ok = 1'b1;
            end
         end
         ACT_POP_LAST: begin
            if (len > 0) begin
               rep.value = list_shadow.pop_back();
               rep.ok    = 1'b1;
            end
         end
         ACT_POP_FIRST: begin
            if (len > 0) begin
               rep.value = list_shadow.pop_front();
               rep.ok    = 1'b1;
            end
         end
         ACT_POP_AT: begin
            if (at < len) begin
               rep.value = list_shadow[at];
               list_shadow.delete(at);
               rep.ok = 1'b1;
            end
         end
         ACT_READ_AT: begin
            if (at < len) begin
               rep.value = list_shadow[at];
               rep.ok    = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rep.count = CNT_OUT_W'(list_shadow.size());
      return rep;
   endfunction

   function automatic void log_fault(string msg);
      if (fail_count < SHOWN_FAULTS) begin
         $display("%s", msg);
      end
      fail_count++;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         list_shadow.delete();
         reply_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (reply_queue.size() == 0) begin
               log_fault($sformatf("unexpected reply: ok=%0b value=%0d count=%0d",
                                   rsp_mon.ok, rsp_mon.read_value, rsp_mon.count));
            end else begin
               want = reply_queue.pop_front();
               if (rsp_mon.ok !== want.ok || rsp_mon.read_value !== want.value ||
                   rsp_mon.count !== want.count) begin
                  log_fault($sformatf({"reply mismatch: expected ok=%0b value=%0d count=%0d,",
                                       " got ok=%0b value=%0d count=%0d"},
                                      want.ok, want.value, want.count,
                                      rsp_mon.ok, rsp_mon.read_value, rsp_mon.count));
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            reply_queue.push_back(apply_request(req_mon.action, req_mon.item_value,
                                                req_mon.position));
         end
      end
      list_len = list_shadow.size();
      pending  = reply_queue.size();
   end

endmodule

// ----- tb/sv/tb_indexed_ordered_list.sv -----
`timescale 1ns / 1ps

module tb_indexed_ordered_list;
   import iol_pkg::*;

   localparam int               LIST_CAP      = DEFAULT_CAPACITY;
   localparam int               HOLD_CYCLES   = 300;
   localparam int               DRAIN_CYCLES  = 64;
   localparam int               PHASE_ITEMS   = 175;
   localparam int               MAX_TARGET    = 40;
   localparam logic [ACT_W-1:0] ACT_UNDEFINED = 3'd7;
   localparam data_type         VALUE_MIN     = data_type'(32'h8000_0000);
   localparam data_type         VALUE_MAX     = data_type'(32'h7FFF_FFFF);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   list_len;
   int   pending;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   bit   hold_start     = 1'b0;
   int   hold_left      = 0;
   int   target_len     = 0;

   iol_req_if req_if ();
   iol_rsp_if rsp_if ();

   indexed_ordered_list #(
      .CAPACITY(LIST_CAP)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   list_reply_checker #(
      .CAPACITY(LIST_CAP)
   ) reply_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .fail_count(fail_count),
      .list_len  (list_len),
      .pending   (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: long hold on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   task automatic send_req(logic [ACT_W-1:0] act, data_type value, logic [POS_W-1:0] pos);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.item_value <= value;
      req_if.position   <= pos;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic data_type pick_value();
      case ($urandom_range(19, 0))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return FAIL_VALUE;
         default: return data_type'($urandom());
      endcase
   endfunction

   task automatic random_req();
      logic [ACT_W-1:0] act;
      logic [POS_W-1:0] pos;
      int               grow_pct;
      if ($urandom_range(15, 0) == 0) begin
         target_len = $urandom_range(MAX_TARGET, 0);
      end
      if ($urandom_range(99, 0) < 5) begin
         act = ACT_W'($urandom_range(7, 0));
         pos = POS_W'($urandom());
      end else begin
         grow_pct = (list_len < target_len) ? 70 : 30;
         if ($urandom_range(99, 0) < grow_pct) begin
            case ($urandom_range(2, 0))
               0:       act = ACT_APPEND;
               1:       act = ACT_PREPEND;
               default: act = ACT_INSERT;
            endcase
            pos = POS_W'($urandom_range(list_len, 0));
         end else begin
            case ($urandom_range(3, 0))
               0:       act = ACT_POP_LAST;
               1:       act = ACT_POP_FIRST;
               2:       act = ACT_POP_AT;
               default: act = ACT_READ_AT;
            endcase
            pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1, 0)) : '0;
         end
         // probe the boundary just past the end
         if ($urandom_range(99, 0) < 8) begin
            pos = POS_W'(list_len + $urandom_range(1, 0));
         end
      end
      send_req(act, pick_value(), pos);
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.action     = ACT_APPEND;
      req_if.item_value = '0;
      req_if.position   = '0;
      rsp_if.ready      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list and undefined action
      send_req(ACT_POP_LAST, '0, '0);
      send_req(ACT_POP_FIRST, '0, '0);
      send_req(ACT_POP_AT, '0, '0);
      send_req(ACT_READ_AT, '0, '0);
      send_req(ACT_INSERT, VALUE_MAX, POS_W'(1));
      send_req(ACT_UNDEFINED, VALUE_MIN, '1);
      // build a short list with extreme values
      send_req(ACT_INSERT, VALUE_MIN, '0);
      send_req(ACT_APPEND, VALUE_MAX, '1);
      send_req(ACT_PREPEND, '0, '1);
      send_req(ACT_APPEND, FAIL_VALUE, '0);
      send_req(ACT_INSERT, data_type'(32'h5555_5555), POS_W'(2));
      send_req(ACT_INSERT, data_type'(32'hAAAA_AAAA), POS_W'(5));
      send_req(ACT_READ_AT, '0, '0);
      send_req(ACT_READ_AT, '0, POS_W'(5));
      send_req(ACT_READ_AT, '0, POS_W'(6));
      send_req(ACT_READ_AT, '0, '1);
      send_req(ACT_INSERT, VALUE_MAX, '1);
      send_req(ACT_POP_AT, '0, POS_W'(2));
      send_req(ACT_POP_AT, '0, POS_W'(5));
      send_req(ACT_POP_FIRST, '0, '0);
      send_req(ACT_POP_LAST, '0, '0);
      send_req(ACT_UNDEFINED, '1, '0);

      // fill to capacity
      while (list_len < LIST_CAP) begin
         case ($urandom_range(2, 0))
            0:       send_req(ACT_APPEND, pick_value(), '0);
            1:       send_req(ACT_PREPEND, pick_value(), '0);
            default: send_req(ACT_INSERT, pick_value(), POS_W'($urandom_range(list_len, 0)));
         endcase
      end
      send_req(ACT_APPEND, VALUE_MAX, '0);
      send_req(ACT_PREPEND, VALUE_MIN, '0);
      send_req(ACT_INSERT, '1, '0);
      send_req(ACT_INSERT, '1, POS_W'(LIST_CAP));
      send_req(ACT_READ_AT, '0, POS_W'(LIST_CAP - 1));
      send_req(ACT_READ_AT, '0, '0);
      send_req(ACT_READ_AT, '0, POS_W'(LIST_CAP));
      send_req(ACT_POP_AT, '0, POS_W'(LIST_CAP - 1));
      send_req(ACT_INSERT, VALUE_MIN, POS_W'(LIST_CAP - 1));
      send_req(ACT_POP_LAST, '0, '0);
      // drain near the head
      while (list_len > 0) begin
         if ($urandom_range(1, 0) == 0) begin
            send_req(ACT_POP_FIRST, '0, '0);
         end else begin
            send_req(ACT_POP_AT, '0, POS_W'($urandom_range(3, 0)));
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 0 && i == 40) begin
               hold_start = 1'b1;
            end
            if (i == 100) begin
               wait_drained();
            end
            random_req();
         end
      end

      wait_drained();
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
